/* sv/rrc_pkg.sv */
// Shared types and constants of the read range coalescer.
`default_nettype none
package rrc_pkg;

    // Field widths
    localparam int OFFSET_BITS = 48;
    localparam int LEN_BITS    = 32;
    // Sums of an offset and a length or of an end and a limit
    localparam int SUM_BITS    = ((OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS) + 2;

    // Configuration register map
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLE_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LIMIT = 1'b1;

    localparam logic [LEN_BITS-1:0] RANGE_LIMIT_RESET = LEN_BITS'(2 * 1024 * 1024);

    // Output queue sizing: room for the two ranges one page can flush
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // One merged read range
    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [LEN_BITS-1:0]    length;
        logic [LEN_BITS-1:0]    pages;
        logic                   last;
    } t_range;

    // Ranges pushed by the merge core in one cycle
    typedef struct packed {
        logic   valid0;
        logic   valid1;
        t_range entry0;
        t_range entry1;
    } t_push;

endpackage
`default_nettype wire

/* sv/rrc_merge.sv */
// Merge core: open range state, configuration registers and merge decision.
`default_nettype none
module rrc_merge (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire logic [rrc_pkg::OFFSET_BITS-1:0]     i_page_offset,
    input  wire logic [rrc_pkg::LEN_BITS-1:0]        i_page_length,
    input  wire logic                                i_batch_last,
    input  wire logic                                i_cfg_write,
    input  wire logic [rrc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [rrc_pkg::LEN_BITS-1:0]        i_cfg_data,
    output rrc_pkg::t_push                           o_push
);

    logic [rrc_pkg::LEN_BITS-1:0]    r_hole_limit;
    logic [rrc_pkg::LEN_BITS-1:0]    r_range_limit;

    logic                            r_open;
    logic [rrc_pkg::OFFSET_BITS-1:0] r_start;
    logic [rrc_pkg::LEN_BITS-1:0]    r_length;
    logic [rrc_pkg::LEN_BITS-1:0]    r_count;
    logic [rrc_pkg::SUM_BITS-1:0]    r_end;

    logic [rrc_pkg::SUM_BITS-1:0]    w_off_x;
    logic [rrc_pkg::SUM_BITS-1:0]    w_start_x;
    logic [rrc_pkg::SUM_BITS-1:0]    w_page_end;
    logic [rrc_pkg::SUM_BITS-1:0]    w_limit_end;
    logic [rrc_pkg::SUM_BITS-1:0]    w_hole_end;
    logic [rrc_pkg::SUM_BITS-1:0]    w_span_grow;
    logic                            w_hole_ok;
    logic                            w_span_ok;
    logic                            w_merge;
    logic                            w_grow;
    logic                            w_emit_old;

    rrc_pkg::t_range                 w_old;
    rrc_pkg::t_range                 w_new;

    logic [rrc_pkg::OFFSET_BITS-1:0] n_start;
    logic [rrc_pkg::LEN_BITS-1:0]    n_length;
    logic [rrc_pkg::LEN_BITS-1:0]    n_count;
    logic [rrc_pkg::SUM_BITS-1:0]    n_end;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hole_limit  <= '0;
            r_range_limit <= rrc_pkg::RANGE_LIMIT_RESET;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                rrc_pkg::REG_HOLE_LIMIT:  r_hole_limit  <= i_cfg_data;
                rrc_pkg::REG_RANGE_LIMIT: r_range_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ends and bounds, each one add wide enough to never wrap
    assign w_off_x     = rrc_pkg::SUM_BITS'(i_page_offset);
    assign w_start_x   = rrc_pkg::SUM_BITS'(r_start);
    assign w_page_end  = w_off_x + rrc_pkg::SUM_BITS'(i_page_length);
    assign w_limit_end = w_start_x + rrc_pkg::SUM_BITS'(r_range_limit);
    assign w_hole_end  = r_end + rrc_pkg::SUM_BITS'(r_hole_limit);
    assign w_span_grow = w_page_end - w_start_x;

    // Gap fits the hole limit; both range end and page end stay within the span limit
    assign w_hole_ok  = (w_off_x <= w_hole_end);
    assign w_span_ok  = (w_page_end <= w_limit_end) && (r_length <= r_range_limit);
    assign w_merge    = r_open && (i_page_offset >= r_start) && w_hole_ok && w_span_ok;
    assign w_grow     = (w_page_end > r_end);
    assign w_emit_old = r_open && !w_merge;

    // Next open range
    always_comb begin
        if (w_merge) begin
            n_start  = r_start;
            n_length = w_grow ? w_span_grow[rrc_pkg::LEN_BITS-1:0] : r_length;
            n_count  = (r_count == '1) ? r_count : r_count + rrc_pkg::LEN_BITS'(1);
            n_end    = w_grow ? w_page_end : r_end;
        end else begin
            n_start  = i_page_offset;
            n_length = i_page_length;
            n_count  = rrc_pkg::LEN_BITS'(1);
            n_end    = w_page_end;
        end
    end

    // Range state; a last page closes the batch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (i_accept) begin
            r_open <= !i_batch_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_start  <= n_start;
            r_length <= n_length;
            r_count  <= n_count;
            r_end    <= n_end;
        end
    end

    // Emitted ranges: the displaced one first, then the flushed one
    always_comb begin
        w_old.offset = r_start;
        w_old.length = r_length;
        w_old.pages  = r_count;
        w_old.last   = 1'b0;
        w_new.offset = n_start;
        w_new.length = n_length;
        w_new.pages  = n_count;
        w_new.last   = 1'b1;
        o_push.valid0 = i_accept && (w_emit_old || i_batch_last);
        o_push.valid1 = i_accept && w_emit_old && i_batch_last;
        o_push.entry0 = w_emit_old ? w_old : w_new;
        o_push.entry1 = w_new;
    end

endmodule
`default_nettype wire

/* sv/rrc_out_fifo.sv */
// Small output queue taking up to two ranges a cycle and giving one.
`default_nettype none
module rrc_out_fifo (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire rrc_pkg::t_push i_push,
    input  wire logic       i_pop,
    output logic            o_valid,
    output rrc_pkg::t_range o_data,
    output logic            o_room
);

    rrc_pkg::t_range                  r_mem [rrc_pkg::FIFO_DEPTH];
    logic [rrc_pkg::FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [rrc_pkg::FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [rrc_pkg::FIFO_CNT_BITS-1:0] r_count;
    logic [rrc_pkg::FIFO_CNT_BITS-1:0] n_count;
    logic [rrc_pkg::FIFO_PTR_BITS-1:0] w_wr_next;
    logic                              w_pop;

    assign w_pop     = i_pop && (r_count != '0);
    assign w_wr_next = r_wr_ptr + rrc_pkg::FIFO_PTR_BITS'(1);
    assign n_count   = r_count
                     + rrc_pkg::FIFO_CNT_BITS'(i_push.valid0)
                     + rrc_pkg::FIFO_CNT_BITS'(i_push.valid1)
                     - rrc_pkg::FIFO_CNT_BITS'(w_pop);

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + rrc_pkg::FIFO_PTR_BITS'(1);
            end
            if (i_push.valid1) begin
                r_wr_ptr <= r_wr_ptr + rrc_pkg::FIFO_PTR_BITS'(2);
            end else if (i_push.valid0) begin
                r_wr_ptr <= w_wr_next;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wr_ptr] <= i_push.entry0;
        end
        if (i_push.valid1) begin
            r_mem[w_wr_next] <= i_push.entry1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    // Room for a page that flushes two ranges
    assign o_room  = (r_count <= rrc_pkg::FIFO_CNT_BITS'(rrc_pkg::FIFO_DEPTH - 2));

endmodule
`default_nettype wire

/* sv/read_range_coalescer_top.sv */
// Read range coalescer: merges ascending page descriptors into read ranges.
//
// Page requests come in on i_valid / o_stall with offset, length and a
// batch-last flag; merged ranges leave on o_valid / i_stall with offset,
// length, page count and a final flag. A request is taken at a clock edge
// with valid high and stall low on its channel.
// One page is taken every cycle while o_stall is low. A page that
// displaces the open range and also ends the batch yields two ranges,
// which leave one after the other. A range enters the output queue at
// the edge that takes the page closing it. A four-entry output queue
// decouples the two sides; o_stall rises when it cannot hold two more
// ranges, so a stalled receiver backs up the input and nothing is lost.
// Limits are written through i_cfg_valid / o_cfg_ready (always ready):
// index 0 is the hole limit, index 1 the range limit.
// Synchronous reset (i_rst_n low) empties the queue, closes any open
// range and restores hole limit 0 and range limit 2 MiB.
`default_nettype none
module read_range_coalescer_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Page requests
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [rrc_pkg::OFFSET_BITS-1:0]  i_page_offset,
    input  wire logic [rrc_pkg::LEN_BITS-1:0]     i_page_length,
    input  wire logic                             i_batch_last,
    // Range requests
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [rrc_pkg::OFFSET_BITS-1:0]       o_range_offset,
    output logic [rrc_pkg::LEN_BITS-1:0]          o_range_length,
    output logic [rrc_pkg::LEN_BITS-1:0]          o_range_pages,
    output logic                                  o_range_final,
    // Configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rrc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [rrc_pkg::LEN_BITS-1:0]     i_cfg_data
);

    logic            w_accept;
    logic            w_room;
    rrc_pkg::t_push  w_push;
    rrc_pkg::t_range w_out;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !w_room;
    assign w_accept    = i_valid && w_room;

    rrc_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_page_offset (i_page_offset),
        .i_page_length (i_page_length),
        .i_batch_last  (i_batch_last),
        .i_cfg_write   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (w_push)
    );

    rrc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_data  (w_out),
        .o_room  (w_room)
    );

    assign o_range_offset = w_out.offset;
    assign o_range_length = w_out.length;
    assign o_range_pages  = w_out.pages;
    assign o_range_final  = w_out.last;

`ifndef SYNTHESIS
    // A second range is only ever pushed along with a first
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid1 |-> w_push.valid0)
        else $error("second range pushed without first");

    // Ranges are only produced by an accepted page
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |-> !w_push.valid0)
        else $error("range pushed without accepted page");

    // A batch-last page always flushes a final range as its last push
    a_last_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_batch_last) |->
            ((w_push.valid1 && w_push.entry1.last && !w_push.entry0.last) ||
             (w_push.valid0 && !w_push.valid1 && w_push.entry0.last)))
        else $error("batch-last page did not flush a final range");

    // Every emitted range covers at least one page
    a_pages_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_range_pages != '0))
        else $error("range emitted with zero pages");
`endif

endmodule
`default_nettype wire

/* tb/read_range_coalescer_top_tb.sv */
// Testbench for the read range coalescer: directed table plus random page streams.
module read_range_coalescer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_ITEMS   = 178;
    localparam int NUM_PHASES    = 7;
    localparam int HOLD_AT_PAGE  = 500;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTED   = 40;

    localparam logic [rrc_pkg::OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [rrc_pkg::LEN_BITS-1:0]    LEN_MAX  = '1;
    localparam rrc_pkg::t_range                 NO_RANGE = '0;

    // One line of the directed table: a page request or a register write
    typedef enum logic {ROW_PAGE, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind                         kind;
        logic [rrc_pkg::OFFSET_BITS-1:0]   off;
        logic [rrc_pkg::LEN_BITS-1:0]      len;
        logic                              last;
        logic [rrc_pkg::CFG_IDX_BITS-1:0]  idx;
        logic [rrc_pkg::LEN_BITS-1:0]      data;
        logic                              typed;
        rrc_pkg::t_range                   want;
    } t_stim_row;

    localparam int NUM_ROWS = 25;
    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        // first page after reset, then both fields at their maximum
        '{ROW_PAGE, 48'h0, 32'h1000, 1'b1, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b1,
          '{48'h0, 32'h1000, 32'd1, 1'b1}},
        '{ROW_PAGE, OFF_MAX, LEN_MAX, 1'b1, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b1,
          '{OFF_MAX, LEN_MAX, 32'd1, 1'b1}},
        // contiguous, overlap inside, overlap extending, gap, page below start
        '{ROW_PAGE, 48'h1000, 32'h1000, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h2000, 32'h1000, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h2800, 32'h400, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h2800, 32'h1000, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h4000, 32'h1000, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h3000, 32'h100, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h3100, 32'h0, 1'b1, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        // gap exactly at the hole limit, one past it, span exactly at the limit
        '{ROW_REG, 48'h0, 32'h0, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h1000, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h10000, 32'h1000, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h12000, 32'h1000, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h14001, 32'h1000, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h15001, 32'h1FF000, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h214001, 32'h1, 1'b1, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        // zero range limit: only empty spans merge
        '{ROW_REG, 48'h0, 32'h0, 1'b0, rrc_pkg::REG_RANGE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h100, 32'h0, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h100, 32'h0, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h100, 32'h1, 1'b1, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        // widest limits, page end past the top of the offset space, wrap below
        '{ROW_REG, 48'h0, 32'h0, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'hFFFF_FFFF, 1'b0,
          NO_RANGE},
        '{ROW_REG, 48'h0, 32'h0, 1'b0, rrc_pkg::REG_RANGE_LIMIT, 32'hFFFF_FFFF, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'hFFFF_FFFF_0000, 32'h8000, 1'b0, rrc_pkg::REG_HOLE_LIMIT, 32'h0,
          1'b0, NO_RANGE},
        '{ROW_PAGE, 48'hFFFF_FFFF_F000, 32'hFFFF_FFFF, 1'b0, rrc_pkg::REG_HOLE_LIMIT,
          32'h0, 1'b0, NO_RANGE},
        '{ROW_PAGE, 48'h0, 32'h10, 1'b1, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE},
        '{ROW_PAGE, 48'h20, 32'h10, 1'b1, rrc_pkg::REG_HOLE_LIMIT, 32'h0, 1'b0,
          NO_RANGE}
    };

    // Block ports
    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic [rrc_pkg::OFFSET_BITS-1:0]    i_page_offset = '0;
    logic [rrc_pkg::LEN_BITS-1:0]       i_page_length = '0;
    logic                               i_batch_last = 1'b0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic [rrc_pkg::OFFSET_BITS-1:0]    o_range_offset;
    logic [rrc_pkg::LEN_BITS-1:0]       o_range_length;
    logic [rrc_pkg::LEN_BITS-1:0]       o_range_pages;
    logic                               o_range_final;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [rrc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic [rrc_pkg::LEN_BITS-1:0]       i_cfg_data = '0;

    read_range_coalescer_top dut (.*);

    // Predictor state and its copy of the limits
    logic                               cov_open;
    logic [rrc_pkg::OFFSET_BITS-1:0]    cov_start;
    logic [rrc_pkg::LEN_BITS-1:0]       cov_len;
    logic [rrc_pkg::LEN_BITS-1:0]       cov_pages;
    logic [rrc_pkg::LEN_BITS-1:0]       hole_lim;
    logic [rrc_pkg::LEN_BITS-1:0]       span_lim;

    rrc_pkg::t_range expected_ranges[$];
    rrc_pkg::t_range head_range;
    int     mismatches = 0;
    int     cycles = 0;
    int     pages_sent = 0;
    int     idle_rate = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("ERROR cycle %0d: %s", cycles, what);
    endtask

    // Append one range to the tail of the expected queue
    task automatic add_expected(input rrc_pkg::t_range rng);
        expected_ranges.insert(expected_ranges.size(), rng);
    endtask

    // Merge one page into the open range; with push set, closed ranges go to the expected queue
    task automatic coalesce_page(input logic [rrc_pkg::OFFSET_BITS-1:0] off,
                                 input logic [rrc_pkg::LEN_BITS-1:0] len,
                                 input logic last, input bit push);
        logic [63:0] cur_end;
        logic [63:0] page_end;
        logic [63:0] hole;
        logic [63:0] new_end;
        logic [63:0] span;
        bit          merged;
        merged = 1'b0;
        if (cov_open) begin
            cur_end  = 64'(cov_start) + 64'(cov_len);
            page_end = 64'(off) + 64'(len);
            if (off >= cov_start) begin
                hole    = (64'(off) > cur_end) ? 64'(off) - cur_end : 64'd0;
                new_end = (page_end > cur_end) ? page_end : cur_end;
                span    = new_end - 64'(cov_start);
                if (hole <= 64'(hole_lim) && span <= 64'(span_lim)) begin
                    merged  = 1'b1;
                    cov_len = span[rrc_pkg::LEN_BITS-1:0];
                    if (cov_pages != LEN_MAX)
                        cov_pages++;
                end
            end
            if (!merged && push)
                add_expected(rrc_pkg::t_range'{cov_start, cov_len, cov_pages, 1'b0});
        end
        if (!cov_open || !merged) begin
            cov_open  = 1'b1;
            cov_start = off;
            cov_len   = len;
            cov_pages = 32'd1;
        end
        // batch end flushes whatever is open
        if (last) begin
            if (push)
                add_expected(rrc_pkg::t_range'{cov_start, cov_len, cov_pages, 1'b1});
            cov_open  = 1'b0;
            cov_start = '0;
            cov_len   = '0;
            cov_pages = '0;
        end
    endtask

    // Offer one page and hold it until the block takes it
    task automatic send_page(input logic [rrc_pkg::OFFSET_BITS-1:0] off,
                             input logic [rrc_pkg::LEN_BITS-1:0] len, input logic last);
        i_valid       <= 1'b1;
        i_page_offset <= off;
        i_page_length <= len;
        i_batch_last  <= last;
        do @(posedge i_clk); while (o_stall);
        pages_sent++;
    endtask

    task automatic sender_gap();
        if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Register write once all ranges are out and the pipeline has settled
    task automatic write_reg(input logic [rrc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [rrc_pkg::LEN_BITS-1:0] data);
        i_valid <= 1'b0;
        while (expected_ranges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == rrc_pkg::REG_HOLE_LIMIT)
            hole_lim = data;
        else
            span_lim = data;
    endtask

    // Receiver: random stall bursts plus one long hold to back up the input
    int  burst_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= (hold_left != 1);
        end else if (!hold_done && pages_sent >= HOLD_AT_PAGE) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (burst_left != 0) begin
            burst_left <= burst_left - 1;
            i_stall    <= (burst_left != 1);
        end else if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate / 3) begin
            burst_left <= $urandom_range(1, 12);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Range checker: every accepted range against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_ranges.size() == 0) begin
                report_mismatch($sformatf("unexpected range offset %h length %h",
                                          o_range_offset, o_range_length));
            end else begin
                head_range = expected_ranges.pop_front();
                if (o_range_offset !== head_range.offset)
                    report_mismatch($sformatf("range_offset %h, expected %h",
                                              o_range_offset, head_range.offset));
                if (o_range_length !== head_range.length)
                    report_mismatch($sformatf("range_length %h, expected %h",
                                              o_range_length, head_range.length));
                if (o_range_pages !== head_range.pages)
                    report_mismatch($sformatf("range_pages %0d, expected %0d",
                                              o_range_pages, head_range.pages));
                if (o_range_final !== head_range.last)
                    report_mismatch($sformatf("range_final %b, expected %b",
                                              o_range_final, head_range.last));
            end
        end
    end

    // Limits for each random phase; the last one runs without idling
    localparam logic [rrc_pkg::LEN_BITS-1:0] PHASE_HOLE [NUM_PHASES] =
        '{32'd0, 32'h1000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd4096};
    localparam logic [rrc_pkg::LEN_BITS-1:0] PHASE_SPAN [NUM_PHASES] =
        '{rrc_pkg::RANGE_LIMIT_RESET, 32'h0010_0000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0,
          rrc_pkg::RANGE_LIMIT_RESET};
    localparam int PHASE_IDLE [NUM_PHASES] = '{20, 35, 0, 25, 30, 15, 0};

    initial begin
        int          phase;
        int          done;
        int          batch_len;
        int          i;
        logic [63:0] rnd;
        logic [63:0] cur_off;
        logic [63:0] prev_off;
        logic [63:0] prev_end;
        logic [31:0] prev_len;
        logic [31:0] len;
        logic [31:0] hole_sel;
        logic [31:0] span_sel;
        logic        lst;

        cov_open  = 1'b0;
        cov_start = '0;
        cov_len   = '0;
        cov_pages = '0;
        hole_lim  = '0;
        span_lim  = rrc_pkg::RANGE_LIMIT_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        idle_rate = 20;
        for (i = 0; i < NUM_ROWS; i++) begin
            if (DIRECTED_ROWS[i].kind == ROW_REG) begin
                write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data);
            end else begin
                sender_gap();
                send_page(DIRECTED_ROWS[i].off, DIRECTED_ROWS[i].len, DIRECTED_ROWS[i].last);
                coalesce_page(DIRECTED_ROWS[i].off, DIRECTED_ROWS[i].len,
                              DIRECTED_ROWS[i].last, !DIRECTED_ROWS[i].typed);
                if (DIRECTED_ROWS[i].typed)
                    add_expected(DIRECTED_ROWS[i].want);
            end
        end

        // Random phases: mostly ascending batches, some noise
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            hole_sel = PHASE_HOLE[phase];
            span_sel = PHASE_SPAN[phase];
            if (phase == 4) begin
                hole_sel = $urandom_range(0, 32'h0010_0000);
                span_sel = $urandom;
            end
            write_reg(rrc_pkg::REG_HOLE_LIMIT, hole_sel);
            write_reg(rrc_pkg::REG_RANGE_LIMIT, span_sel);
            idle_rate = PHASE_IDLE[phase];
            done = 0;
            while (done < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise page: anything at all
                    rnd = {$urandom, $urandom};
                    len = $urandom;
                    lst = 1'($urandom_range(0, 1));
                    sender_gap();
                    send_page(rnd[rrc_pkg::OFFSET_BITS-1:0], len, lst);
                    coalesce_page(rnd[rrc_pkg::OFFSET_BITS-1:0], len, lst, 1'b1);
                    done++;
                end else begin
                    batch_len = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 60)
                                                            : $urandom_range(1, 12);
                    rnd = {$urandom, $urandom};
                    case ($urandom_range(0, 3))
                        0:       cur_off = 64'(OFF_MAX) - 64'($urandom_range(0, 1 << 20));
                        1:       cur_off = 64'($urandom_range(0, 1 << 24));
                        default: cur_off = 64'(rnd[rrc_pkg::OFFSET_BITS-1:0]);
                    endcase
                    prev_off = cur_off;
                    prev_len = '0;
                    for (i = 0; i < batch_len; i++) begin
                        prev_end = prev_off + 64'(prev_len);
                        if (i != 0) begin
                            case ($urandom_range(0, 9))
                                0, 1, 2: cur_off = prev_end;
                                3:       cur_off = prev_end + 64'(hole_lim);
                                4:       cur_off = prev_end + 64'(hole_lim) + 64'd1;
                                5:       cur_off = prev_end + 64'($urandom_range(0, 65535));
                                6:       cur_off = prev_off + 64'($urandom_range(0, prev_len));
                                7:       cur_off = prev_off;
                                8:       cur_off = prev_end + 64'($urandom);
                                default: cur_off = prev_off - 64'($urandom_range(1, 4096));
                            endcase
                        end
                        case ($urandom_range(0, 7))
                            0, 1: len = 32'd4096;
                            2:    len = $urandom_range(0, 8192);
                            3:    len = '0;
                            4:    len = (span_lim >= 2) ? $urandom_range(0, span_lim / 2) : '0;
                            5:    len = (span_lim > 16) ? span_lim - $urandom_range(0, 16)
                                                        : $urandom_range(0, 16);
                            6:    len = $urandom;
                            default: len = 32'd4096 * $urandom_range(1, 64);
                        endcase
                        lst = (i == batch_len - 1);
                        sender_gap();
                        send_page(cur_off[rrc_pkg::OFFSET_BITS-1:0], len, lst);
                        coalesce_page(cur_off[rrc_pkg::OFFSET_BITS-1:0], len, lst, 1'b1);
                        done++;
                        prev_off = 64'(cur_off[rrc_pkg::OFFSET_BITS-1:0]);
                        prev_len = len;
                    end
                end
            end
        end

        // Drain and settle
        i_valid <= 1'b0;
        while (expected_ranges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/rrc_pkg.sv
sv/rrc_merge.sv
sv/rrc_out_fifo.sv
sv/read_range_coalescer_top.sv
tb/read_range_coalescer_top_tb.sv
